// ----- hw/rtl/lmvc_pkg.sv -----
package lmvc_pkg;

  localparam int LMVC_FRAC_BITS = 16;
  localparam int LMVC_ONE       = 1 << LMVC_FRAC_BITS;

  // Thresholds rounded to the fixed-point grid
  localparam int LMVC_C_STOP  = (LMVC_ONE + 50) / 100;
  localparam int LMVC_C_SHORT = (LMVC_ONE * 6 + 5) / 10;
  localparam int LMVC_C_SMALL = (LMVC_ONE + 5) / 10;
  localparam int LMVC_C_BIAS  = (LMVC_ONE + 500) / 1000;

  localparam logic [17:0] LMVC_GAIN_P_RST  = 18'd6554;
  localparam logic [17:0] LMVC_GAIN_I_RST  = 18'd26214;
  localparam logic [17:0] LMVC_GAIN_D_RST  = 18'd52429;
  localparam logic [22:0] LMVC_MAX_VEL_RST = 23'd32768;

  localparam int LMVC_SQRT_STEPS = 25;
  localparam int LMVC_DIV_STEPS  = 17;

  typedef enum logic [1:0] {
    REG_GAIN_P  = 2'd0,
    REG_GAIN_I  = 2'd1,
    REG_GAIN_D  = 2'd2,
    REG_MAX_VEL = 2'd3
  } lmvc_reg_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } lmvc_kind_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ST_SQX, S_ST_SQY, S_ST_SUM, S_ST_ROOTW,
    S_ST_DIVX, S_ST_DIVXW, S_ST_DIVY, S_ST_DIVYW,
    S_ST_PV, S_ST_PVW,
    S_TK_CHK, S_TK_P, S_TK_D, S_TK_C, S_TK_X, S_TK_E2, S_TK_LO, S_TK_HI,
    S_TK_SUM, S_TK_AX, S_TK_AY, S_TK_AYW,
    S_TK_T1, S_TK_T2, S_TK_T3, S_TK_ROOTW, S_TK_FIN
  } lmvc_state_e;

  // Request to the shared root / divide unit
  typedef struct packed {
    logic        is_sqrt;
    logic [49:0] src;      // bits fed in from the top, MSB first
    logic [27:0] rem;      // initial partial remainder
    logic [24:0] divisor;
  } lmvc_iter_req_t;

  function automatic logic signed [23:0] lmvc_sat24(logic signed [44:0] v);
    logic signed [23:0] r;
    if (v > 45'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -45'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Scale a velocity by a split ratio, apply the axis sign, saturate
  function automatic logic signed [23:0] lmvc_axis(logic signed [65:0] prod, logic neg);
    logic signed [24:0] m;
    logic signed [44:0] r;
    m = prod[40:16];
    r = neg ? -45'(m) : 45'(m);
    return lmvc_sat24(r);
  endfunction

endpackage

// ----- hw/rtl/lmvc_iter.sv -----
module lmvc_iter (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  lmvc_pkg::lmvc_iter_req_t req_i,
  output logic                    done_o,
  output logic [24:0]             res_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        sqrt_q;
  logic [49:0] src_q;
  logic [27:0] rem_q;
  logic [24:0] root_q;
  logic [24:0] div_q;

  logic [27:0] rem_sh;
  logic [27:0] trial;
  logic        ge;

  // One digit per cycle: shift in, compare, subtract
  always_comb begin
    rem_sh = sqrt_q ? {rem_q[25:0], src_q[49:48]} : {rem_q[26:0], src_q[49]};
    trial  = sqrt_q ? {1'b0, root_q, 2'b01} : {3'b0, div_q};
    ge     = rem_sh >= trial;
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = req_i.is_sqrt ? 5'(lmvc_pkg::LMVC_SQRT_STEPS) : 5'(lmvc_pkg::LMVC_DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sqrt_q <= req_i.is_sqrt;
      src_q  <= req_i.src;
      rem_q  <= req_i.rem;
      div_q  <= req_i.divisor;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[23:0], ge};
      src_q  <= sqrt_q ? {src_q[47:0], 2'b00} : {src_q[48:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = root_q;

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without a running operation");
  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("start while busy");
  a_cnt_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 5'd0) else $error("busy with empty step count");

endmodule

// ----- hw/rtl/linear_move_velocity_controller_top.sv -----
// Linear move velocity controller. A start item (kind 0) latches the move and
// produces no result; a tick item (kind 1) during a move produces one velocity
// item, plus a final zero-velocity item with finished set when the odometry
// distance reaches the goal, or only a single stop item when the goal or the
// remaining distance is under 0.01; a tick with no move produces nothing. One
// item is processed at a time and in_stall_o stays high until it is done. All
// multiplies run through one 33x33 multiplier, and one shared unit does floor
// square roots (25 steps) and ratio divides (17 steps). A start does one root,
// two divides and three multiplies; a start with zero displacement skips the
// divides. A tick does eleven multiplies and one root, plus a final state when
// it ends in a stop item, plus any wait for the output slot. A tick that stops
// at once goes straight back to idle from its check state once the output slot
// is free. Results wait in an output register, so the next item can be taken
// while a result is still stalled; a tick that needs to emit waits only for
// that slot.
module linear_move_velocity_controller_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic signed [23:0] target_dx_i,
  input  logic signed [23:0] target_dy_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic        [19:0] elapsed_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] vel_x_o,
  output logic signed [23:0] vel_y_o,
  output logic               finished_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  // ---------------------------------------------------------------- config
  logic [17:0] gain_p_q, gain_i_q, gain_d_q;
  logic [22:0] max_vel_q;
  lmvc_pkg::lmvc_reg_e reg_sel;

  assign reg_sel = lmvc_pkg::lmvc_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= lmvc_pkg::LMVC_GAIN_P_RST;
      gain_i_q  <= lmvc_pkg::LMVC_GAIN_I_RST;
      gain_d_q  <= lmvc_pkg::LMVC_GAIN_D_RST;
      max_vel_q <= lmvc_pkg::LMVC_MAX_VEL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        lmvc_pkg::REG_GAIN_P:  gain_p_q  <= pwdata[17:0];
        lmvc_pkg::REG_GAIN_I:  gain_i_q  <= pwdata[17:0];
        lmvc_pkg::REG_GAIN_D:  gain_d_q  <= pwdata[17:0];
        lmvc_pkg::REG_MAX_VEL: max_vel_q <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lmvc_pkg::REG_GAIN_P:  prdata = {14'b0, gain_p_q};
      lmvc_pkg::REG_GAIN_I:  prdata = {14'b0, gain_i_q};
      lmvc_pkg::REG_GAIN_D:  prdata = {14'b0, gain_d_q};
      lmvc_pkg::REG_MAX_VEL: prdata = {9'b0, max_vel_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  lmvc_pkg::lmvc_state_e state_q, state_d;

  logic               kind_q;
  logic signed [23:0] dx_q, dy_q, px_q, py_q;
  logic        [19:0] el_q;

  logic               moving_q;
  logic signed [23:0] start_x_q, start_y_q;
  logic        [23:0] goal_q, trav_q;
  logic        [16:0] split_x_q, split_y_q;
  logic               neg_x_q, neg_y_q;
  logic signed [23:0] prev_q, vel_q, ox_q;

  // tick scratch
  logic        [24:0] e_q;
  logic        [26:0] p_q;
  logic signed [25:0] d_q;
  logic        [31:0] x_q;
  logic        [39:0] e2_q;
  logic        [51:0] lo_q;
  logic        [49:0] acc_q;

  // output slot
  logic               out_vld_q;
  logic signed [23:0] vx_q, vy_q;
  logic               fin_q;
  logic               out_free;
  logic               out_load;

  assign out_free = !out_vld_q || !out_stall_i;
  assign in_stall_o = (state_q != lmvc_pkg::S_IDLE);

  // ---------------------------------------------------------------- helpers
  logic        [23:0] ax, ay;
  logic        [24:0] axy;
  logic signed [24:0] dpx, dpy;
  logic signed [25:0] remain;
  logic               stop_now;
  logic        [22:0] coef;
  logic        [72:0] prod;
  logic        [42:0] it;
  logic signed [44:0] vsum;
  logic        [23:0] root_sat;
  logic signed [24:0] prev_w, lim;

  logic               it_start, it_done;
  logic        [24:0] it_res;
  lmvc_pkg::lmvc_iter_req_t it_req;

  logic               mul_en;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mq_q;

  always_comb begin
    ax       = dx_q[23] ? 24'(-dx_q) : 24'(dx_q);
    ay       = dy_q[23] ? 24'(-dy_q) : 24'(dy_q);
    axy      = {1'b0, ax} + {1'b0, ay};
    dpx      = 25'(px_q) - 25'(start_x_q);
    dpy      = 25'(py_q) - 25'(start_y_q);
    remain   = $signed({2'b0, goal_q}) - $signed({2'b0, trav_q});
    stop_now = (goal_q < 24'(lmvc_pkg::LMVC_C_STOP)) ||
               (remain < $signed(26'(lmvc_pkg::LMVC_C_STOP)));
    // small goals use a fixed 1.25 * gain_i coefficient
    coef     = (goal_q <= 24'(lmvc_pkg::LMVC_C_SMALL)) ?
               23'(({3'b0, gain_i_q, 2'b00} + {5'b0, gain_i_q}) >> 2) : mq_q[41:19];
    // time term: x * elapsed^2 from two partial products
    prod     = {1'b0, mq_q[51:0], 20'b0} + {21'b0, lo_q};
    it       = (prod[72:63] != '0 || (prod[62] && prod[61:0] != '0)) ?
               43'h400_0000_0000 : prod[62:20];
    vsum     = $signed({18'b0, p_q}) - 45'(d_q) + $signed({2'b0, it});
    root_sat = it_res[24] ? 24'hFFFFFF : it_res[23:0];
    prev_w   = 25'(prev_q);
    lim      = $signed({2'b0, max_vel_q});
  end

  // load the output slot with a stop or velocity item
  assign out_load = out_free &&
                    ((state_q == lmvc_pkg::S_TK_CHK && moving_q && stop_now) ||
                     state_q == lmvc_pkg::S_TK_AYW || state_q == lmvc_pkg::S_TK_FIN);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lmvc_pkg::S_IDLE:
        if (in_valid_i) begin
          state_d = (kind_i == lmvc_pkg::KIND_TICK) ? lmvc_pkg::S_TK_CHK : lmvc_pkg::S_ST_SQX;
        end
      lmvc_pkg::S_ST_SQX:   state_d = lmvc_pkg::S_ST_SQY;
      lmvc_pkg::S_ST_SQY:   state_d = lmvc_pkg::S_ST_SUM;
      lmvc_pkg::S_ST_SUM:   state_d = lmvc_pkg::S_ST_ROOTW;
      lmvc_pkg::S_ST_ROOTW:
        if (it_done) begin
          state_d = (axy == '0) ? lmvc_pkg::S_ST_PV : lmvc_pkg::S_ST_DIVX;
        end
      lmvc_pkg::S_ST_DIVX:  state_d = lmvc_pkg::S_ST_DIVXW;
      lmvc_pkg::S_ST_DIVXW: if (it_done) state_d = lmvc_pkg::S_ST_DIVY;
      lmvc_pkg::S_ST_DIVY:  state_d = lmvc_pkg::S_ST_DIVYW;
      lmvc_pkg::S_ST_DIVYW: if (it_done) state_d = lmvc_pkg::S_ST_PV;
      lmvc_pkg::S_ST_PV:    state_d = lmvc_pkg::S_ST_PVW;
      lmvc_pkg::S_ST_PVW:   state_d = lmvc_pkg::S_IDLE;
      lmvc_pkg::S_TK_CHK:
        if (!moving_q) begin
          state_d = lmvc_pkg::S_IDLE;
        end else if (stop_now) begin
          if (out_free) state_d = lmvc_pkg::S_IDLE;
        end else begin
          state_d = lmvc_pkg::S_TK_P;
        end
      lmvc_pkg::S_TK_P:     state_d = lmvc_pkg::S_TK_D;
      lmvc_pkg::S_TK_D:     state_d = lmvc_pkg::S_TK_C;
      lmvc_pkg::S_TK_C:     state_d = lmvc_pkg::S_TK_X;
      lmvc_pkg::S_TK_X:     state_d = lmvc_pkg::S_TK_E2;
      lmvc_pkg::S_TK_E2:    state_d = lmvc_pkg::S_TK_LO;
      lmvc_pkg::S_TK_LO:    state_d = lmvc_pkg::S_TK_HI;
      lmvc_pkg::S_TK_HI:    state_d = lmvc_pkg::S_TK_SUM;
      lmvc_pkg::S_TK_SUM:   state_d = lmvc_pkg::S_TK_AX;
      lmvc_pkg::S_TK_AX:    state_d = lmvc_pkg::S_TK_AY;
      lmvc_pkg::S_TK_AY:    state_d = lmvc_pkg::S_TK_AYW;
      lmvc_pkg::S_TK_AYW:   if (out_free) state_d = lmvc_pkg::S_TK_T1;
      lmvc_pkg::S_TK_T1:    state_d = lmvc_pkg::S_TK_T2;
      lmvc_pkg::S_TK_T2:    state_d = lmvc_pkg::S_TK_T3;
      lmvc_pkg::S_TK_T3:    state_d = lmvc_pkg::S_TK_ROOTW;
      lmvc_pkg::S_TK_ROOTW:
        if (it_done) begin
          state_d = (root_sat >= goal_q) ? lmvc_pkg::S_TK_FIN : lmvc_pkg::S_IDLE;
        end
      lmvc_pkg::S_TK_FIN:   if (out_free) state_d = lmvc_pkg::S_IDLE;
      default:              state_d = lmvc_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- unit control
  always_comb begin
    mul_en   = 1'b1;
    mul_a    = '0;
    mul_b    = '0;
    it_start = 1'b0;
    it_req   = '0;
    unique case (state_q)
      lmvc_pkg::S_ST_SQX: begin mul_a = 33'(dx_q); mul_b = 33'(dx_q); end
      lmvc_pkg::S_ST_SQY: begin mul_a = 33'(dy_q); mul_b = 33'(dy_q); end
      lmvc_pkg::S_ST_SUM, lmvc_pkg::S_TK_T3: begin
        mul_en         = 1'b0;
        it_start       = 1'b1;
        it_req.is_sqrt = 1'b1;
        it_req.src     = acc_q + mq_q[49:0];
      end
      lmvc_pkg::S_ST_DIVX: begin
        mul_en         = 1'b0;
        it_start       = 1'b1;
        it_req.src     = {ax[0], 49'b0};
        it_req.rem     = {5'b0, ax[23:1]};
        it_req.divisor = axy;
      end
      lmvc_pkg::S_ST_DIVY: begin
        mul_en         = 1'b0;
        it_start       = 1'b1;
        it_req.src     = {ay[0], 49'b0};
        it_req.rem     = {5'b0, ay[23:1]};
        it_req.divisor = axy;
      end
      lmvc_pkg::S_ST_PV: begin
        mul_a = $signed({15'b0, gain_p_q}); mul_b = $signed({9'b0, goal_q});
      end
      lmvc_pkg::S_TK_P: begin
        mul_a = $signed({15'b0, gain_p_q}); mul_b = $signed({8'b0, e_q});
      end
      lmvc_pkg::S_TK_D: begin
        mul_a = $signed({15'b0, gain_d_q}); mul_b = 33'(prev_q);
      end
      lmvc_pkg::S_TK_C: begin
        mul_a = $signed({15'b0, gain_i_q}); mul_b = $signed({9'b0, goal_q});
      end
      lmvc_pkg::S_TK_X: begin
        mul_a = $signed({10'b0, coef}); mul_b = $signed({8'b0, e_q});
      end
      lmvc_pkg::S_TK_E2: begin
        mul_a = $signed({13'b0, el_q}); mul_b = $signed({13'b0, el_q});
      end
      lmvc_pkg::S_TK_LO: begin
        mul_a = $signed({1'b0, x_q}); mul_b = $signed({13'b0, mq_q[19:0]});
      end
      lmvc_pkg::S_TK_HI: begin
        mul_a = $signed({1'b0, x_q}); mul_b = $signed({13'b0, e2_q[39:20]});
      end
      lmvc_pkg::S_TK_AX: begin
        mul_a = 33'(vel_q); mul_b = $signed({16'b0, split_x_q});
      end
      lmvc_pkg::S_TK_AY: begin
        mul_a = 33'(vel_q); mul_b = $signed({16'b0, split_y_q});
      end
      lmvc_pkg::S_TK_T1: begin mul_a = 33'(dpx); mul_b = 33'(dpx); end
      lmvc_pkg::S_TK_T2: begin mul_a = 33'(dpy); mul_b = 33'(dpy); end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mq_q <= mul_a * mul_b;
    end
  end

  lmvc_iter u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (it_start),
    .req_i   (it_req),
    .done_o  (it_done),
    .res_o   (it_res)
  );

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lmvc_pkg::S_IDLE;
      moving_q  <= 1'b0;
      out_vld_q <= 1'b0;
      start_x_q <= '0;
      start_y_q <= '0;
      goal_q    <= '0;
      trav_q    <= '0;
      split_x_q <= '0;
      split_y_q <= '0;
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      prev_q    <= '0;
    end else begin
      state_q <= state_d;
      // load a new item, else drop the slot once taken
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        lmvc_pkg::S_ST_ROOTW:
          if (it_done) begin
            goal_q <= root_sat;
            if (axy == '0) begin
              split_x_q <= '0;
              split_y_q <= '0;
            end
          end
        lmvc_pkg::S_ST_DIVXW: if (it_done) split_x_q <= it_res[16:0];
        lmvc_pkg::S_ST_DIVYW: if (it_done) split_y_q <= it_res[16:0];
        lmvc_pkg::S_ST_PVW: begin
          prev_q    <= (mq_q[41:39] != 3'b000) ? 24'sh7FFFFF : $signed(mq_q[39:16]);
          start_x_q <= px_q;
          start_y_q <= py_q;
          neg_x_q   <= !(dx_q > 24'sd0);
          neg_y_q   <= !(dy_q > 24'sd0);
          trav_q    <= '0;
          moving_q  <= 1'b1;
        end
        lmvc_pkg::S_TK_CHK:
          if (moving_q) begin
            if (stop_now) begin
              if (out_free) moving_q <= 1'b0;
            end else if (goal_q < 24'(lmvc_pkg::LMVC_C_SHORT)) begin
              // short move: hold the previous velocity inside the step limit
              if (prev_w > lim) begin
                prev_q <= 24'(lim);
              end else if (prev_w < -lim) begin
                prev_q <= 24'(-lim);
              end
            end
          end
        lmvc_pkg::S_TK_SUM: prev_q <= lmvc_pkg::lmvc_sat24(vsum);
        lmvc_pkg::S_TK_ROOTW: if (it_done) trav_q <= root_sat;
        lmvc_pkg::S_TK_FIN: if (out_free) moving_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (state_q == lmvc_pkg::S_IDLE && in_valid_i) begin
      kind_q <= kind_i;
      dx_q   <= target_dx_i;
      dy_q   <= target_dy_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      el_q   <= elapsed_i;
    end
    unique case (state_q)
      lmvc_pkg::S_ST_SQY, lmvc_pkg::S_TK_T2: acc_q <= mq_q[49:0];
      lmvc_pkg::S_TK_CHK: begin
        e_q <= 25'({2'b0, goal_q} + 26'(lmvc_pkg::LMVC_C_BIAS) - {2'b0, trav_q});
        if (stop_now && out_free) begin
          vx_q  <= '0;
          vy_q  <= '0;
          fin_q <= 1'b1;
        end
      end
      lmvc_pkg::S_TK_D:   p_q  <= mq_q[42:16];
      lmvc_pkg::S_TK_C:   d_q  <= mq_q[41:16];
      lmvc_pkg::S_TK_E2:  x_q  <= mq_q[47:16];
      lmvc_pkg::S_TK_LO:  e2_q <= mq_q[39:0];
      lmvc_pkg::S_TK_HI:  lo_q <= mq_q[51:0];
      lmvc_pkg::S_TK_SUM: vel_q <= lmvc_pkg::lmvc_sat24(vsum);
      lmvc_pkg::S_TK_AY:  ox_q <= lmvc_pkg::lmvc_axis(mq_q, neg_x_q);
      lmvc_pkg::S_TK_AYW:
        if (out_free) begin
          vx_q  <= ox_q;
          vy_q  <= lmvc_pkg::lmvc_axis(mq_q, neg_y_q);
          fin_q <= 1'b0;
        end
      lmvc_pkg::S_TK_FIN:
        if (out_free) begin
          vx_q  <= '0;
          vy_q  <= '0;
          fin_q <= 1'b1;
        end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign vel_x_o     = vx_q;
  assign vel_y_o     = vy_q;
  assign finished_o  = fin_q;

  a_stop_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && fin_q |-> vx_q == '0 && vy_q == '0)
    else $error("stop item carries a nonzero velocity");
  a_tick_needs_move : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lmvc_pkg::S_TK_P |-> moving_q && kind_q == lmvc_pkg::KIND_TICK)
    else $error("tick math without an active move");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(vx_q) && $stable(vy_q) &&
    $stable(fin_q))
    else $error("stalled result item changed");

endmodule

// ----- tb/linear_move_velocity_controller_top_tb.sv -----
module linear_move_velocity_controller_top_tb;

  // One input item as driven onto the ports
  typedef struct {
    lmvc_pkg::lmvc_kind_e kind;
    logic [23:0] dx;
    logic [23:0] dy;
    logic [23:0] px;
    logic [23:0] py;
    logic [19:0] el;
  } move_cmd_t;

  // One velocity command as it should leave the block
  typedef struct {
    logic [23:0] vx;
    logic [23:0] vy;
    logic        fin;
  } vel_cmd_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int LONG_HOLD      = 2000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall;
  logic kind;
  logic signed [23:0] target_dx, target_dy, pos_x, pos_y, vel_x, vel_y;
  logic [19:0] elapsed;
  logic finished;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  linear_move_velocity_controller_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .target_dx_i(target_dx), .target_dy_i(target_dy),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .elapsed_i(elapsed),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .vel_x_o(vel_x), .vel_y_o(vel_y), .finished_o(finished),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Controller state mirrored by the predictor
  logic [17:0] cfg_gain_p, cfg_gain_i, cfg_gain_d;
  logic [22:0] cfg_max_vel;
  logic        mv_active;
  longint      mv_start_x, mv_start_y, mv_prev_vel;
  longint      mv_goal, mv_split_x, mv_split_y, mv_travelled;
  logic        mv_neg_x, mv_neg_y;

  move_cmd_t pending_cmds[$];
  vel_cmd_t  vel_expect_q[$];

  int errors, items_in, results_out, moves_started, stops_seen, idle_cycles;
  logic cmd_taken;
  int burst_left, gap_left, stall_hold, stall_mode, stall_mode_left;
  logic pressure_done;

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint floor_root(longint a, longint b);
    longint unsigned n, r, bit_v;
    n = a * a + b * b;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return (r > 64'd16777215) ? 64'd16777215 : longint'(r);
  endfunction

  function automatic logic [23:0] axis_vel(longint v, longint split, logic neg);
    longint m;
    m = (v * split) >>> 16;
    if (neg) m = -m;
    return 24'(sat24(m));
  endfunction

  function automatic vel_cmd_t stop_cmd();
    vel_cmd_t c;
    c.vx = '0;
    c.vy = '0;
    c.fin = 1'b1;
    return c;
  endfunction

  // Advance the mirrored state by one accepted item and queue its results
  task automatic predict_velocity(move_cmd_t c);
    longint px, py, dx, dy, ax, ay, e, p, d, vel, it;
    longint unsigned coef, x, e2, el;
    vel_cmd_t r;
    px = longint'(signed'(c.px));
    py = longint'(signed'(c.py));
    if (c.kind == lmvc_pkg::KIND_START) begin
      dx = longint'(signed'(c.dx));
      dy = longint'(signed'(c.dy));
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      mv_start_x = px;
      mv_start_y = py;
      mv_goal = floor_root(dx, dy);
      if (ax + ay == 0) begin
        mv_split_x = 0;
        mv_split_y = 0;
      end else begin
        mv_split_x = (ax << 16) / (ax + ay);
        mv_split_y = (ay << 16) / (ax + ay);
      end
      mv_neg_x = !(dx > 0);
      mv_neg_y = !(dy > 0);
      mv_prev_vel = sat24((longint'(cfg_gain_p) * mv_goal) >>> 16);
      mv_travelled = 0;
      mv_active = 1'b1;
      moves_started++;
      return;
    end
    if (!mv_active) return;
    if (mv_goal < lmvc_pkg::LMVC_C_STOP ||
        mv_goal - mv_travelled < lmvc_pkg::LMVC_C_STOP) begin
      vel_expect_q.push_back(stop_cmd());
      mv_active = 1'b0;
      return;
    end
    // Clamp the carried velocity on short moves
    if (mv_goal < lmvc_pkg::LMVC_C_SHORT) begin
      if (mv_prev_vel > longint'(cfg_max_vel)) mv_prev_vel = longint'(cfg_max_vel);
      else if (mv_prev_vel < -longint'(cfg_max_vel)) mv_prev_vel = -longint'(cfg_max_vel);
    end
    e = mv_goal + lmvc_pkg::LMVC_C_BIAS - mv_travelled;
    p = (longint'(cfg_gain_p) * e) >>> 16;
    d = (longint'(cfg_gain_d) * mv_prev_vel) >>> 16;
    if (mv_goal <= lmvc_pkg::LMVC_C_SMALL) coef = (longint'(cfg_gain_i) * 5) >> 2;
    else coef = (longint'(cfg_gain_i) * mv_goal) >> (lmvc_pkg::LMVC_FRAC_BITS + 3);
    x = (coef * longint'(e)) >> 16;
    el = c.el;
    e2 = el * el;
    if (e2 != 0 && x > (64'd1 << 62) / e2) it = 64'sd1 <<< 42;
    else it = longint'((x * e2) >> 20);
    vel = sat24(p - d + it);
    r.vx = axis_vel(vel, mv_split_x, mv_neg_x);
    r.vy = axis_vel(vel, mv_split_y, mv_neg_y);
    r.fin = 1'b0;
    vel_expect_q.push_back(r);
    mv_prev_vel = vel;
    mv_travelled = floor_root(px - mv_start_x, py - mv_start_y);
    if (mv_travelled >= mv_goal) begin
      vel_expect_q.push_back(stop_cmd());
      mv_active = 1'b0;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: feed pending items in bursts, hold the payload until taken
  always @(negedge clk_i or negedge rst_ni) begin
    move_cmd_t c;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      kind <= lmvc_pkg::KIND_START;
      target_dx <= '0; target_dy <= '0; pos_x <= '0; pos_y <= '0; elapsed <= '0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (in_valid && !cmd_taken) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() > 0) begin
      c = pending_cmds.pop_front();
      in_valid <= 1'b1;
      kind <= c.kind;
      target_dx <= c.dx; target_dy <= c.dy;
      pos_x <= c.px; pos_y <= c.py; elapsed <= c.el;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: switch between free flow, light and heavy back-pressure
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
      stall_mode <= 0;
      stall_mode_left <= 50;
      pressure_done <= 1'b0;
    end else if (!pressure_done && items_in >= 300) begin
      // one long hold-off so the block backs up into its input
      pressure_done <= 1'b1;
      stall_hold <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_mode_left <= $urandom_range(20, 400);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Monitor: predict on accepted inputs, check accepted results
  always @(posedge clk_i) begin
    move_cmd_t c;
    vel_cmd_t want;
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        c.kind = lmvc_pkg::lmvc_kind_e'(kind);
        c.dx = target_dx; c.dy = target_dy;
        c.px = pos_x; c.py = pos_y; c.el = elapsed;
        predict_velocity(c);
        items_in++;
      end
      if (out_valid && !out_stall) begin
        results_out++;
        if (finished) stops_seen++;
        if (vel_expect_q.size() == 0) begin
          $display("%0t: unexpected result vel_x=%0d vel_y=%0d finished=%0b",
                   $time, vel_x, vel_y, finished);
          errors++;
        end else begin
          want = vel_expect_q.pop_front();
          if (vel_x !== want.vx) begin
            $display("%0t: vel_x expected %0d actual %0d", $time, signed'(want.vx), vel_x);
            errors++;
          end
          if (vel_y !== want.vy) begin
            $display("%0t: vel_y expected %0d actual %0d", $time, signed'(want.vy), vel_y);
            errors++;
          end
          if (finished !== want.fin) begin
            $display("%0t: finished expected %0b actual %0b", $time, want.fin, finished);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress, %0d results still expected", $time, vel_expect_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Write one register over the config port and mirror it
  task automatic write_reg(lmvc_pkg::lmvc_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lmvc_pkg::REG_GAIN_P:  cfg_gain_p = value[17:0];
      lmvc_pkg::REG_GAIN_I:  cfg_gain_i = value[17:0];
      lmvc_pkg::REG_GAIN_D:  cfg_gain_d = value[17:0];
      lmvc_pkg::REG_MAX_VEL: cfg_max_vel = value[22:0];
      default: ;
    endcase
  endtask

  function automatic logic [23:0] clip24(longint v);
    return 24'(sat24(v));
  endfunction

  task automatic push_cmd(lmvc_pkg::lmvc_kind_e k, longint dx, longint dy, longint px,
                          longint py, longint el);
    move_cmd_t c;
    c.kind = k;
    c.dx = clip24(dx); c.dy = clip24(dy);
    c.px = clip24(px); c.py = clip24(py);
    c.el = 20'(el);
    pending_cmds.push_back(c);
  endtask

  function automatic longint rand_signed24();
    return longint'(signed'(24'($urandom())));
  endfunction

  // A well-formed move: start, then ticks walking from the start point to
  // the goal, sometimes going past it
  task automatic queue_move();
    longint dx, dy, x0, y0, el, k, n, sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      dx = rand_signed24(); dy = rand_signed24();
    end else if (sel < 3) begin
      dx = $urandom_range(0, 1300) - 650; dy = $urandom_range(0, 1300) - 650;
    end else if (sel < 8) begin
      dx = $urandom_range(0, 78000) - 39000; dy = $urandom_range(0, 78000) - 39000;
    end else begin
      dx = $urandom_range(0, 600000) - 300000; dy = $urandom_range(0, 600000) - 300000;
    end
    if ($urandom_range(0, 9) == 0) dy = 0;
    x0 = $urandom_range(0, 4000000) - 2000000;
    y0 = $urandom_range(0, 4000000) - 2000000;
    if ($urandom_range(0, 15) == 0) x0 = rand_signed24();
    push_cmd(lmvc_pkg::KIND_START, dx, dy, x0, y0, 0);
    n = $urandom_range(1, 8);
    el = 0;
    for (k = 1; k <= n + $urandom_range(0, 2); k++) begin
      el = el + $urandom_range(10, 200);
      if ($urandom_range(0, 30) == 0) el = $urandom_range(0, 1048575);
      push_cmd(lmvc_pkg::KIND_TICK, rand_signed24(), rand_signed24(),
               x0 + dx * k / n + $urandom_range(0, 200) - 100,
               y0 + dy * k / n + $urandom_range(0, 200) - 100, el);
    end
  endtask

  task automatic queue_noise();
    push_cmd(lmvc_pkg::lmvc_kind_e'($urandom_range(0, 1)), rand_signed24(), rand_signed24(),
             rand_signed24(), rand_signed24(), $urandom_range(0, 1048575));
  endtask

  task automatic queue_directed();
    // tick while idle, then a full-scale diagonal with the time term pegged
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 0, 0, 100);
    push_cmd(lmvc_pkg::KIND_START, 8388607, -8388608, -8388608, 8388607, 0);
    push_cmd(lmvc_pkg::KIND_TICK, -8388608, 8388607, -8388608, 8388607, 1048575);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 8388607, -8388608, 0);
    // zero displacement stops at once
    push_cmd(lmvc_pkg::KIND_START, 0, 0, 1000, -1000, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 1000, -1000, 5);
    // tiny move under the stop distance
    push_cmd(lmvc_pkg::KIND_START, 300, -200, 0, 0, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 0, 0, 10);
    // short move with a clamped carried velocity, negative x only
    push_cmd(lmvc_pkg::KIND_START, -30000, 0, 0, 0, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, -100, 0, 50);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, -10000, 0, 100);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, -30000, 0, 150);
    // restart mid-move, then arrive with overshoot
    push_cmd(lmvc_pkg::KIND_START, 200000, 100000, 0, 0, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 1000, 500, 20);
    push_cmd(lmvc_pkg::KIND_START, 5000, 200000, 0, 0, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 0, 100000, 300);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 10000, 250000, 600);
    // stop once remaining distance drops under the stop distance
    push_cmd(lmvc_pkg::KIND_START, 100000, 0, 0, 0, 0);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 99800, 0, 40);
    push_cmd(lmvc_pkg::KIND_TICK, 0, 0, 99800, 0, 80);
  endtask

  // Run one phase to completion, then let the block settle before reconfig
  task automatic run_phase(int n_items);
    int n;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_move();
        n += 6;
      end else begin
        queue_noise();
        n++;
      end
    end
    wait (pending_cmds.size() == 0 && !in_valid);
    wait (vel_expect_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_gain_p = lmvc_pkg::LMVC_GAIN_P_RST; cfg_gain_i = lmvc_pkg::LMVC_GAIN_I_RST;
    cfg_gain_d = lmvc_pkg::LMVC_GAIN_D_RST; cfg_max_vel = lmvc_pkg::LMVC_MAX_VEL_RST;
    mv_active = 1'b0;
    mv_start_x = 0; mv_start_y = 0; mv_prev_vel = 0; mv_goal = 0;
    mv_split_x = 0; mv_split_y = 0; mv_travelled = 0;
    mv_neg_x = 1'b0; mv_neg_y = 1'b0;
    errors = 0; items_in = 0; results_out = 0; moves_started = 0; stops_seen = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset gains first, directed cases included
    queue_directed();
    run_phase(130);
    // every register at its maximum
    write_reg(lmvc_pkg::REG_GAIN_P, 32'h3FFFF);
    write_reg(lmvc_pkg::REG_GAIN_I, 32'h3FFFF);
    write_reg(lmvc_pkg::REG_GAIN_D, 32'h3FFFF);
    write_reg(lmvc_pkg::REG_MAX_VEL, 32'h7FFFFF);
    queue_directed();
    run_phase(130);
    // every register at zero
    write_reg(lmvc_pkg::REG_GAIN_P, 0);
    write_reg(lmvc_pkg::REG_GAIN_I, 0);
    write_reg(lmvc_pkg::REG_GAIN_D, 0);
    write_reg(lmvc_pkg::REG_MAX_VEL, 0);
    run_phase(130);
    // two random settings
    repeat (2) begin
      write_reg(lmvc_pkg::REG_GAIN_P, $urandom_range(0, 262143));
      write_reg(lmvc_pkg::REG_GAIN_I, $urandom_range(0, 262143));
      write_reg(lmvc_pkg::REG_GAIN_D, $urandom_range(0, 262143));
      write_reg(lmvc_pkg::REG_MAX_VEL, $urandom_range(0, 8388607));
      run_phase(150);
    end

    $display("Ran %0d items over %0d moves and five gain settings; checked %0d results",
             items_in, moves_started, results_out);
    $display("including %0d stop commands, %0d mismatches", stops_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/lmvc_pkg.sv
hw/rtl/lmvc_iter.sv
hw/rtl/linear_move_velocity_controller_top.sv
tb/linear_move_velocity_controller_top_tb.sv
